/* design/sample_playback_mixer_assert.svh */
// Assertion macros for the sample playback mixer.
`ifndef SAMPLE_PLAYBACK_MIXER_ASSERT_SVH
`define SAMPLE_PLAYBACK_MIXER_ASSERT_SVH
`ifndef SYNTHESIS
`define SPM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SPM_ASSERT(label, clk, rst_n, prop, msg)
`define SPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* design/spm_pkg.sv */
// ----------------------------------------------------------------------------
// spm_pkg
// Shared types and constants of the sample playback mixer.
// ----------------------------------------------------------------------------
package spm_pkg;
  localparam int unsigned SampleDepth = 65536;
  localparam int unsigned Playheads   = 8;
  localparam int unsigned SampleBits  = 16;
  localparam int unsigned PosBits     = 25;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 17;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_PLAY   = 2'd1,
    KIND_STOP   = 2'd2,
    KIND_RENDER = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    REG_CHANNELS      = 3'd0,
    REG_FRAME_COUNT   = 3'd1,
    REG_VELOCITY      = 3'd2,
    REG_MASTER_VEL    = 3'd3,
    REG_VOLUME        = 3'd4,
    REG_LOOP          = 3'd5,
    REG_MUTE          = 3'd6,
    REG_PAUSE         = 3'd7
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_ADDR,
    ST_READ,
    ST_ACC,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [3:0]  chan_count;
    logic [16:0] frame_count;
    logic signed [15:0] velocity;
    logic signed [15:0] master_velocity;
    logic signed [15:0] volume;
    logic loop_enable;
    logic mute_enable;
    logic pause_enable;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  channel;
    logic [15:0] address;
    logic [15:0] sample_value;
  } in_word_t;

  typedef struct packed {
    logic [31:0] mixed;
    logic [3:0]  active_playheads;
  } out_word_t;
endpackage

/* design/spm_in_if.sv */
// ----------------------------------------------------------------------------
// spm_in_if
// Valid-ready input channel of the sample playback mixer.
// ----------------------------------------------------------------------------
interface spm_in_if import spm_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/spm_out_if.sv */
// ----------------------------------------------------------------------------
// spm_out_if
// Result channel of the sample playback mixer.
// ----------------------------------------------------------------------------
interface spm_out_if import spm_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/sample_playback_mixer.sv */
// ----------------------------------------------------------------------------
// sample_playback_mixer
// Variable-rate sample playback voice mixer with a shared multiplier.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// in_if     in   kind, channel, address, sample_value
// out_if    out  mixed, active_playheads
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i
//
// Load, play and stop words may follow back to back.
// A render word closes the input while it runs: one step product, then per
// slot an address product, a store read and a volume product on the one
// multiplier, then a closing cycle; under pause only the step and closing.
// The closing cycle holds while the previous result still waits unaccepted.
// Reset clears control state and live bits; the store has no clearing pass.
`include "sample_playback_mixer_assert.svh"

module sample_playback_mixer import spm_pkg::*; #(
  parameter int unsigned SAMPLE_DEPTH = SampleDepth,
  parameter int unsigned PLAYHEADS    = Playheads,
  parameter int unsigned SAMPLE_BITS  = SampleBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  spm_in_if.sink                 in_if,
  spm_out_if.source              out_if,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);
  localparam int unsigned AddrBits = $clog2(SAMPLE_DEPTH);
  localparam int unsigned SlotBits = (PLAYHEADS > 1) ? $clog2(PLAYHEADS) : 1;
  localparam int unsigned CntBits  = $clog2(PLAYHEADS + 1);
  localparam int unsigned MulABits = (SAMPLE_BITS > 18) ? SAMPLE_BITS : 18;
  localparam int unsigned ProdBits = MulABits + 16;
  localparam int unsigned AccBits  = ProdBits + SlotBits + 1;
  localparam int unsigned NpBits   = PosBits + 3;
  localparam int unsigned StepBits = NpBits - 1;
  localparam logic signed [AccBits-1:0] QMax = AccBits'(32767);
  localparam logic signed [AccBits-1:0] QMin = AccBits'(-32768);

  cfg_t cfg_q;
  state_e state_q, state_d;
  logic [2:0] chan_q;
  logic [PLAYHEADS-1:0] live_q;
  logic [PosBits-1:0] pos_q [PLAYHEADS];
  logic [SlotBits-1:0] slot_q;
  logic signed [AccBits-1:0] acc_q;
  logic acc_pend_q;
  logic signed [StepBits-1:0] step_q;
  logic out_valid_q;
  out_word_t out_q;

  logic signed [MulABits-1:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [ProdBits-1:0] prod;
  logic [SAMPLE_BITS-1:0] rdata;
  logic ram_we;
  logic [AddrBits-1:0] ram_addr;
  logic [SAMPLE_BITS-1:0] ram_wdata;
  logic accept, last_slot, paused, last_ch, slot_live, done_go;
  logic [16:0] frame;
  logic signed [NpBits-1:0] np;
  logic out_range;
  logic [PLAYHEADS-1:0] free_first;
  logic [CntBits-1:0] live_cnt;
  logic signed [AccBits-1:0] total;
  logic signed [AccBits-1:0] shifted;
  logic signed [15:0] q15;

  assign accept      = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == ST_IDLE);
  assign last_slot   = (slot_q == SlotBits'(PLAYHEADS - 1));
  assign paused      = cfg_q.pause_enable;
  assign last_ch     = (cfg_q.chan_count != 4'd0) &&
                       ({1'b0, chan_q} == cfg_q.chan_count - 4'd1);
  assign slot_live   = live_q[slot_q];
  assign frame       = pos_q[slot_q][PosBits-1:8];
  // Hold the closing cycle until the result register is free.
  assign done_go     = (state_q == ST_DONE) && (!out_valid_q || out_if.ready);

  // Store: loads write at their accept edge; renders read in READ.
  assign ram_we    = accept && (in_if.data.kind == KIND_LOAD);
  assign ram_wdata = SAMPLE_BITS'($signed(in_if.data.sample_value));

  spm_ram #(.Width(SAMPLE_BITS), .Depth(SAMPLE_DEPTH)) u_store (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wdata), .rdata_o(rdata)
  );

  spm_mac #(.AWidth(MulABits)) u_mac (
    .clk_i, .a_i(mul_a), .b_i(mul_b), .p_o(prod)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && in_if.data.kind == KIND_RENDER) state_d = ST_STEP;
      end
      ST_STEP: state_d = paused ? ST_DONE : ST_ADDR;
      ST_ADDR: state_d = ST_READ;
      ST_READ: state_d = ST_ACC;
      ST_ACC:  state_d = last_slot ? ST_DONE : ST_ADDR;
      ST_DONE: begin
        if (done_go) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Multiplier operands and store address per state. The product is registered
  // and lands in the next state: the step in the first ADDR, the address in READ and
  // the contribution in the cycle after ACC.
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    ram_addr = AddrBits'(in_if.data.address);
    unique case (state_q)
      ST_STEP: begin
        mul_a = MulABits'($signed(cfg_q.velocity));
        mul_b = cfg_q.master_velocity;
      end
      ST_ADDR: begin
        mul_a = MulABits'({1'b0, frame});
        mul_b = {12'd0, cfg_q.chan_count};
      end
      ST_READ: begin
        ram_addr = AddrBits'(prod) + AddrBits'(chan_q);
      end
      ST_ACC: begin
        mul_a = MulABits'($signed(rdata));
        mul_b = cfg_q.mute_enable ? 16'sd0 : cfg_q.volume;
      end
      default: ;
    endcase
  end

  // Move, range check, free slot, live count and saturation.
  always_comb begin
    np = $signed({3'b000, pos_q[slot_q]}) + (last_ch ? NpBits'(step_q) : NpBits'(0));
    out_range = np[NpBits-1] || (np[NpBits-2:8] >= {2'b00, cfg_q.frame_count});
    free_first = ~live_q & (live_q + 1'b1);
    live_cnt = '0;
    for (int i = 0; i < PLAYHEADS; i++) begin
      live_cnt = live_cnt + CntBits'(live_q[i]);
    end
    total = acc_q + (acc_pend_q ? AccBits'(prod) : AccBits'(0));
    shifted = total >>> (SAMPLE_BITS - 1);
    if (shifted > QMax)      q15 = 16'sh7fff;
    else if (shifted < QMin) q15 = 16'sh8000;
    else                     q15 = 16'(shifted);
  end

  always_ff @(posedge clk_i) begin
    if (accept) chan_q <= in_if.data.channel;
    // The step product is ready in the first slot's ADDR cycle.
    if (state_q == ST_ADDR && slot_q == '0) step_q <= StepBits'(prod >>> 8);
    if (state_q == ST_STEP) acc_q <= '0;
    else if (acc_pend_q)    acc_q <= total;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= '{chan_count: 4'd1, frame_count: 17'd1, velocity: 16'sd256,
                       master_velocity: 16'sd256, volume: 16'sd32767,
                       loop_enable: 1'b0, mute_enable: 1'b0, pause_enable: 1'b0};
      live_q      <= '0;
      slot_q      <= '0;
      acc_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      acc_pend_q <= (state_q == ST_ACC) && slot_live;
      if (cfg_we_i) begin
        unique case (reg_e'(cfg_idx_i))
          REG_CHANNELS:      cfg_q.chan_count      <= cfg_data_i[3:0];
          REG_FRAME_COUNT:   cfg_q.frame_count     <= cfg_data_i;
          REG_VELOCITY:      cfg_q.velocity        <= cfg_data_i[15:0];
          REG_MASTER_VEL:    cfg_q.master_velocity <= cfg_data_i[15:0];
          REG_VOLUME:        cfg_q.volume          <= cfg_data_i[15:0];
          REG_LOOP:          cfg_q.loop_enable     <= cfg_data_i[0];
          REG_MUTE:          cfg_q.mute_enable     <= cfg_data_i[0];
          REG_PAUSE:         cfg_q.pause_enable    <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (accept) begin
        if (in_if.data.kind == KIND_PLAY) live_q <= live_q | free_first;
        if (in_if.data.kind == KIND_STOP) live_q <= '0;
      end
      // Drop a playhead that left the sound unless looping.
      if (state_q == ST_ACC && slot_live && out_range && !cfg_q.loop_enable) begin
        live_q[slot_q] <= 1'b0;
      end
      if (state_q == ST_STEP) slot_q <= '0;
      else if (state_q == ST_ACC && !last_slot) slot_q <= slot_q + 1'b1;
      if (done_go) out_valid_q <= 1'b1;
      else if (out_if.valid && out_if.ready) out_valid_q <= 1'b0;
    end
  end

  // Positions: payload storage, no reset.
  always_ff @(posedge clk_i) begin
    if (accept && in_if.data.kind == KIND_PLAY) begin
      for (int i = 0; i < PLAYHEADS; i++) begin
        if (free_first[i]) pos_q[i] <= '0;
      end
    end
    // Advance the playhead after its sample is taken.
    if (state_q == ST_ACC && slot_live) begin
      if (out_range) begin
        if (!cfg_q.velocity[15] || cfg_q.frame_count == 17'd0) pos_q[slot_q] <= '0;
        else pos_q[slot_q] <= {cfg_q.frame_count - 17'd1, 8'd0};
      end else begin
        pos_q[slot_q] <= np[PosBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_go) begin
      out_q.mixed <= {q15, 16'd0};
      out_q.active_playheads <= 4'(live_cnt);
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

  `SPM_ASSERT(a_busy_not_ready, clk_i, rst_ni,
    (state_q != ST_IDLE) |-> !in_if.ready, "ready while busy")
  `SPM_ASSERT_NEXT(a_done_valid, clk_i, rst_ni, state_q == ST_DONE,
    out_if.valid, "result not shown after render")
  `SPM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_if.valid && !out_if.ready,
    out_if.valid, "result dropped before accept")
  `SPM_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_if.valid && !out_if.ready,
    $stable(out_if.data), "result changed while waiting")
endmodule

/* design/spm_ram.sv */
// ----------------------------------------------------------------------------
// spm_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module spm_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

/* design/spm_mac.sv */
// ----------------------------------------------------------------------------
// spm_mac
// Shared multiplier: one product per cycle, registered.
// ----------------------------------------------------------------------------
module spm_mac #(
  parameter int unsigned AWidth = 18
) (
  input  logic                       clk_i,
  input  logic signed [AWidth-1:0]   a_i,
  input  logic signed [15:0]         b_i,
  output logic signed [AWidth+15:0]  p_o
);
  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end
endmodule
